FILE: design/bdarc_pkg.sv
package bdarc_pkg;

    // Default parameter values
    localparam int PRESS_SETTLE_TICKS_DEF   = 15;
    localparam int RELEASE_SETTLE_TICKS_DEF = 20;
    localparam int REPEAT_TICKS_DEF         = 30;
    localparam int VALUE_BITS_DEF           = 8;

    // Fixed field widths
    localparam int CNT_W   = 5;
    localparam int BTN_W   = 4;
    localparam int RANGE_W = 8;
    localparam int DISP_W  = 8;

    // Register reset values
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST = 8'd0;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST = 8'd16;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_RANGE_MIN = 1'b0,
        REG_RANGE_MAX = 1'b1
    } reg_idx_t;

    // Input word kinds
    typedef enum logic [1:0] {
        KIND_PRESS = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    // Button action codes
    localparam logic [BTN_W-1:0] CODE_INC  = 4'd4;
    localparam logic [BTN_W-1:0] CODE_NEXT = 4'd8;

    // Debounce phases
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PRESS   = 2'd1,
        PH_HELD    = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

endpackage

FILE: design/button_debounce_auto_repeat_counter.sv
// The result word is registered: it is presented in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready is high; a new word can be taken in the cycle
// the previous result is drained, so in_ready only drops while a result waits on a stall.
// All work is one pass of compare-and-count logic between the state and result registers.
// Reset (rst_n low, asynchronous): phase idle, counters, offset and next flag cleared,
// range_min = 0, range_max = 16, no result pending.
module button_debounce_auto_repeat_counter
    import bdarc_pkg::*;
#(
    parameter int PRESS_SETTLE_TICKS   = PRESS_SETTLE_TICKS_DEF,
    parameter int RELEASE_SETTLE_TICKS = RELEASE_SETTLE_TICKS_DEF,
    parameter int REPEAT_TICKS         = REPEAT_TICKS_DEF,
    parameter int VALUE_BITS           = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [RANGE_W-1:0] cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [BTN_W-1:0]   pending_buttons,
    input  logic               buttons_released,
    input  logic [7:0]         set_value,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [DISP_W-1:0]  display_value,
    output logic               display_update,
    output logic               next_flag,
    output logic               buttons_armed
);

    localparam int WB = (VALUE_BITS > RANGE_W) ? VALUE_BITS : RANGE_W;
    localparam logic [CNT_W-1:0] PRESS_LIM   = CNT_W'(PRESS_SETTLE_TICKS);
    localparam logic [CNT_W-1:0] RELEASE_LIM = CNT_W'(RELEASE_SETTLE_TICKS);
    localparam logic [CNT_W-1:0] REPEAT_LIM  = CNT_W'(REPEAT_TICKS);
    localparam logic [DISP_W-1:0] DISP_MASK  =
        (VALUE_BITS >= DISP_W) ? {DISP_W{1'b1}} : DISP_W'((1 << VALUE_BITS) - 1);

    logic [RANGE_W-1:0]    range_min_reg;
    logic [RANGE_W-1:0]    range_max_reg;
    phase_t                phase_reg, phase_next;
    logic [CNT_W-1:0]      settle_count_reg, settle_count_next;
    logic [CNT_W-1:0]      repeat_count_reg, repeat_count_next;
    logic [BTN_W-1:0]      latched_buttons_reg, latched_buttons_next;
    logic [VALUE_BITS-1:0] value_offset_reg, value_offset_next;
    logic                  next_pending_reg, next_pending_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DISP_W-1:0]     display_value_reg, display_value_next;
    logic                  display_update_reg, display_update_next;
    logic                  buttons_armed_reg;

    logic                  in_fire;
    logic                  press_take;
    logic                  repeat_take;
    logic                  action_take;
    logic [BTN_W-1:0]      action_code;
    logic [CNT_W-1:0]      repeat_inc;
    logic [RANGE_W-1:0]    span_top;
    logic                  inc_wrap;
    logic [RANGE_W-1:0]    write_hi;
    logic [RANGE_W-1:0]    write_lo_sat;
    logic [RANGE_W-1:0]    write_sat;
    logic [WB-1:0]         write_diff;
    logic [WB-1:0]         disp_sum;

    // Handshake: accept while the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Decide which words run a button action
    assign repeat_inc  = repeat_count_reg + CNT_W'(1);
    assign press_take  = in_fire && (kind == KIND_PRESS) && (phase_reg == PH_IDLE);
    assign repeat_take = in_fire && (kind == KIND_TICK) && (phase_reg == PH_HELD)
                         && !buttons_released && (repeat_inc == REPEAT_LIM);
    assign action_take = press_take || repeat_take;
    assign action_code = press_take ? pending_buttons : latched_buttons_reg;

    // Increment wraps past the span; an inverted range counts as empty
    assign span_top = (range_max_reg >= range_min_reg) ? (range_max_reg - range_min_reg)
                                                        : '0;
    assign inc_wrap = WB'(value_offset_reg) >= WB'(span_top);

    // Saturate a written value into the range
    assign write_hi     = (range_max_reg >= range_min_reg) ? range_max_reg : range_min_reg;
    assign write_lo_sat = (set_value < range_min_reg) ? range_min_reg : set_value;
    assign write_sat    = (write_lo_sat > write_hi) ? write_hi : write_lo_sat;
    assign write_diff   = WB'(write_sat - range_min_reg);

    // Next phase and counters
    always_comb
    begin
        phase_next           = phase_reg;
        settle_count_next    = settle_count_reg;
        repeat_count_next    = repeat_count_reg;
        latched_buttons_next = latched_buttons_reg;
        if (press_take)
        begin
            latched_buttons_next = pending_buttons;
            settle_count_next    = '0;
            phase_next           = PH_PRESS;
        end
        else if (in_fire && (kind == KIND_TICK))
        begin
            unique case (phase_reg)
                PH_PRESS:
                begin
                    if (settle_count_reg == PRESS_LIM)
                    begin
                        phase_next        = PH_HELD;
                        repeat_count_next = '0;
                    end
                    else
                    begin
                        settle_count_next = settle_count_reg + CNT_W'(1);
                    end
                end
                PH_HELD:
                begin
                    if (!buttons_released)
                    begin
                        repeat_count_next = (repeat_inc == REPEAT_LIM) ? '0 : repeat_inc;
                    end
                    else
                    begin
                        settle_count_next = '0;
                        phase_next        = PH_RELEASE;
                    end
                end
                PH_RELEASE:
                begin
                    if (settle_count_reg == RELEASE_LIM)
                        phase_next = PH_IDLE;
                    else
                        settle_count_next = settle_count_reg + CNT_W'(1);
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Value offset, next flag and result word
    always_comb
    begin
        value_offset_next   = value_offset_reg;
        next_pending_next   = next_pending_reg;
        display_update_next = 1'b0;
        if (action_take && (action_code == CODE_INC))
        begin
            value_offset_next   = inc_wrap ? '0 : value_offset_reg + VALUE_BITS'(1);
            display_update_next = 1'b1;
        end
        else if (action_take && (action_code == CODE_NEXT))
        begin
            next_pending_next = 1'b1;
        end
        if (in_fire)
        begin
            case (kind)
                KIND_WRITE:
                begin
                    value_offset_next   = write_diff[VALUE_BITS-1:0];
                    display_update_next = 1'b1;
                end
                KIND_CLEAR:
                begin
                    next_pending_next = 1'b0;
                end
                default:
                begin
                    next_pending_next = next_pending_next;
                end
            endcase
        end
        disp_sum           = WB'(value_offset_next) + WB'(range_min_reg);
        display_value_next = disp_sum[DISP_W-1:0] & DISP_MASK;
        out_valid_next     = in_fire || (out_valid_reg && !out_ready);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_RANGE_MIN)
                range_min_reg <= cfg_data;
            else
                range_max_reg <= cfg_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            settle_count_reg    <= '0;
            repeat_count_reg    <= '0;
            latched_buttons_reg <= '0;
            value_offset_reg    <= '0;
            next_pending_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            settle_count_reg    <= settle_count_next;
            repeat_count_reg    <= repeat_count_next;
            latched_buttons_reg <= latched_buttons_next;
            value_offset_reg    <= value_offset_next;
            next_pending_reg    <= next_pending_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            display_value_reg  <= display_value_next;
            display_update_reg <= display_update_next;
            buttons_armed_reg  <= (phase_next == PH_IDLE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign display_value  = display_value_reg;
    assign display_update = display_update_reg;
    assign next_flag      = next_pending_reg;
    assign buttons_armed  = buttons_armed_reg;

    // Checks
    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted word produced no result");

    a_armed_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (buttons_armed_reg == (phase_reg == PH_IDLE)))
        else $error("armed flag disagrees with phase");

    a_press_settle_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PRESS) |-> (settle_count_reg <= PRESS_LIM))
        else $error("press settle count overran");

    a_repeat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HELD) |-> (repeat_count_reg < REPEAT_LIM))
        else $error("repeat count overran");

endmodule

FILE: bench/display_word_checker.sv
`timescale 1ns / 1ps

module display_word_checker
    import bdarc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [RANGE_W-1:0] cfg_data,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [BTN_W-1:0]   pending_buttons,
    input  logic               buttons_released,
    input  logic [7:0]         set_value,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [DISP_W-1:0]  display_value,
    input  logic               display_update,
    input  logic               next_flag,
    input  logic               buttons_armed,

    output int                 fail_count,
    output int                 pending_words
);

    typedef struct packed {
        logic [DISP_W-1:0] value;
        logic              update;
        logic              nflag;
        logic              armed;
    } display_word_t;

    // Own copy of the range registers and of the debouncer state
    logic [RANGE_W-1:0] lo_bound;
    logic [RANGE_W-1:0] hi_bound;
    phase_t             dbnc_phase;
    logic [CNT_W-1:0]   settle_cnt;
    logic [CNT_W-1:0]   repeat_cnt;
    logic [BTN_W-1:0]   held_code;
    logic [7:0]         offset;
    logic               next_sticky;

    display_word_t      expected_display[$];
    int                 mismatch_total;

    assign fail_count = mismatch_total;

    // Run the button action; return high when it was an increment
    function automatic logic apply_action(input logic [BTN_W-1:0] code);
        logic [7:0] span;
        span = (hi_bound >= lo_bound) ? (hi_bound - lo_bound) : 8'd0;
        apply_action = 1'b0;
        if (code == CODE_INC)
        begin
            if (offset >= span)
                offset = 8'd0;
            else
                offset = offset + 8'd1;
            apply_action = 1'b1;
        end
        else if (code == CODE_NEXT)
        begin
            next_sticky = 1'b1;
        end
    endfunction

    // Advance the debouncer by one input word and form the display word
    function automatic display_word_t predict_display(input logic [1:0] k,
                                                      input logic [BTN_W-1:0] pb,
                                                      input logic rel,
                                                      input logic [7:0] sv);
        display_word_t w;
        logic [7:0]    top;
        logic [7:0]    v;
        logic          bumped;
        bumped = 1'b0;
        case (kind_t'(k))
            KIND_PRESS:
            begin
                if (dbnc_phase == PH_IDLE)
                begin
                    held_code  = pb;
                    bumped     = apply_action(pb);
                    settle_cnt = '0;
                    dbnc_phase = PH_PRESS;
                end
            end
            KIND_TICK:
            begin
                if (dbnc_phase == PH_PRESS)
                begin
                    if (settle_cnt == PRESS_SETTLE_TICKS_DEF)
                    begin
                        dbnc_phase = PH_HELD;
                        repeat_cnt = '0;
                    end
                    else
                        settle_cnt = settle_cnt + 1'b1;
                end
                else if (dbnc_phase == PH_HELD)
                begin
                    if (!rel)
                    begin
                        repeat_cnt = repeat_cnt + 1'b1;
                        if (repeat_cnt == REPEAT_TICKS_DEF)
                        begin
                            bumped     = apply_action(held_code);
                            repeat_cnt = '0;
                        end
                    end
                    else
                    begin
                        settle_cnt = '0;
                        dbnc_phase = PH_RELEASE;
                    end
                end
                else if (dbnc_phase == PH_RELEASE)
                begin
                    if (settle_cnt == RELEASE_SETTLE_TICKS_DEF)
                        dbnc_phase = PH_IDLE;
                    else
                        settle_cnt = settle_cnt + 1'b1;
                end
            end
            KIND_WRITE:
            begin
                // Saturate into the range; an inverted range collapses to its minimum
                top = (hi_bound >= lo_bound) ? hi_bound : lo_bound;
                v   = sv;
                if (v < lo_bound)
                    v = lo_bound;
                if (v > top)
                    v = top;
                offset = v - lo_bound;
                bumped = 1'b1;
            end
            default:
            begin
                next_sticky = 1'b0;
            end
        endcase
        w.value  = offset + lo_bound;
        w.update = bumped;
        w.nflag  = next_sticky;
        w.armed  = (dbnc_phase == PH_IDLE);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        display_word_t got;
        display_word_t want;
        if (!rst_n)
        begin
            lo_bound       = RANGE_MIN_RST;
            hi_bound       = RANGE_MAX_RST;
            dbnc_phase     = PH_IDLE;
            settle_cnt     = '0;
            repeat_cnt     = '0;
            held_code      = '0;
            offset         = '0;
            next_sticky    = 1'b0;
            mismatch_total = 0;
            expected_display.delete();
            pending_words <= 0;
        end
        else
        begin
            // Compare each delivered word with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{display_value, display_update, next_flag, buttons_armed};
                if (expected_display.size() == 0)
                begin
                    if (mismatch_total < 10)
                        $display("unexpected word: value %0d update %0b next %0b armed %0b",
                                 got.value, got.update, got.nflag, got.armed);
                    mismatch_total = mismatch_total + 1;
                end
                else
                begin
                    want = expected_display.pop_front();
                    if (got !== want)
                    begin
                        if (mismatch_total < 10)
                            $display("mismatch: value %0d/%0d update %0b/%0b next %0b/%0b armed %0b/%0b (exp/got)",
                                     want.value, got.value, want.update, got.update,
                                     want.nflag, got.nflag, want.armed, got.armed);
                        mismatch_total = mismatch_total + 1;
                    end
                end
            end

            // Track register writes
            if (cfg_write)
            begin
                if (cfg_index == REG_RANGE_MIN)
                    lo_bound = cfg_data;
                else
                    hi_bound = cfg_data;
            end

            // Predict for each accepted word
            if (in_valid && in_ready)
                expected_display.push_back(predict_display(kind, pending_buttons,
                                                           buttons_released, set_value));

            pending_words <= expected_display.size();
        end
    end

endmodule

FILE: bench/button_debounce_auto_repeat_counter_test.sv
`timescale 1ns / 1ps

module button_debounce_auto_repeat_counter_test;
    import bdarc_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [0:0]         cfg_index;
    logic [RANGE_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         kind;
    logic [BTN_W-1:0]   pending_buttons;
    logic               buttons_released;
    logic [7:0]         set_value;
    logic               out_valid;
    logic               out_ready;
    logic [DISP_W-1:0]  display_value;
    logic               display_update;
    logic               next_flag;
    logic               buttons_armed;

    int fail_count;
    int pending_words;
    int tx_idle_pct;
    int rx_stall_pct;
    int words_sent;

    button_debounce_auto_repeat_counter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .pending_buttons  (pending_buttons),
        .buttons_released (buttons_released),
        .set_value        (set_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .display_value    (display_value),
        .display_update   (display_update),
        .next_flag        (next_flag),
        .buttons_armed    (buttons_armed)
    );

    display_word_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .kind             (kind),
        .pending_buttons  (pending_buttons),
        .buttons_released (buttons_released),
        .set_value        (set_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .display_value    (display_value),
        .display_update   (display_update),
        .next_flag        (next_flag),
        .buttons_armed    (buttons_armed),
        .fail_count       (fail_count),
        .pending_words    (pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_word(input kind_t k, input logic [BTN_W-1:0] pb,
                             input logic rel, input logic [7:0] sv);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        kind             <= k;
        pending_buttons  <= pb;
        buttons_released <= rel;
        set_value        <= sv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent = words_sent + 1;
    endtask

    // Hold off until every predicted word has been delivered
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_range(input logic [7:0] lo, input logic [7:0] hi);
        cfg_write <= 1'b1;
        cfg_index <= REG_RANGE_MIN;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_RANGE_MAX;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Tick, now and then preceded by a stray write, clear or press
    task automatic send_tick(input logic rel);
        int pick;
        if ($urandom_range(99) < 12)
        begin
            pick = $urandom_range(2);
            if (pick == 0)
                send_word(KIND_WRITE, 4'($urandom_range(15)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            else if (pick == 1)
                send_word(KIND_CLEAR, 4'($urandom_range(15)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
            else
                send_word(KIND_PRESS, 4'($urandom_range(15)), 1'($urandom_range(1)),
                          8'($urandom_range(255)));
        end
        send_word(KIND_TICK, 4'($urandom_range(15)), rel, 8'($urandom_range(255)));
    endtask

    // Press, hold through settling and repeats, then release back to idle
    task automatic run_button_sequence();
        int               pick;
        int               hold_ticks;
        int               release_ticks;
        logic [BTN_W-1:0] mask;
        pick = $urandom_range(9);
        if (pick < 4)
            mask = CODE_INC;
        else if (pick < 7)
            mask = CODE_NEXT;
        else if (pick == 7)
            mask = CODE_INC | CODE_NEXT;
        else
            mask = 4'($urandom_range(15));
        send_word(KIND_PRESS, mask, 1'($urandom_range(1)), 8'($urandom_range(255)));
        // Hold long enough for a repeat now and then, else release early
        hold_ticks = ($urandom_range(2) == 0) ? $urandom_range(54, 47) : $urandom_range(16, 2);
        repeat (hold_ticks) send_tick($urandom_range(19) == 0);
        release_ticks = $urandom_range(26, 18);
        repeat (release_ticks) send_tick($urandom_range(9) != 0);
    endtask

    initial
    begin : stimulus
        logic [7:0] lo_tab[8];
        logic [7:0] hi_tab[8];
        lo_tab = '{8'd0, 8'd0,   8'd255, 8'd10, 8'd200, 8'd250, 8'd0, 8'd30};
        hi_tab = '{8'd16, 8'd255, 8'd255, 8'd20, 8'd50,  8'd255, 8'd0, 8'd40};

        tx_idle_pct      = 0;
        rx_stall_pct     = 0;
        words_sent       = 0;
        rst_n            <= 1'b0;
        cfg_write        <= 1'b0;
        cfg_index        <= REG_RANGE_MIN;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        kind             <= KIND_TICK;
        pending_buttons  <= '0;
        buttons_released <= 1'b0;
        set_value        <= '0;
        out_ready        <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ticks while idle have no effect
        send_word(KIND_TICK, 4'd0, 1'b0, 8'd0);
        send_word(KIND_TICK, 4'd15, 1'b1, 8'd255);
        // Writes at and beyond the default range, then clear
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd255);
        send_word(KIND_WRITE, 4'd15, 1'b1, 8'd0);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd7);
        send_word(KIND_CLEAR, 4'd15, 1'b1, 8'd0);
        // Both buttons at once do nothing; later presses are ignored until idle
        send_word(KIND_PRESS, CODE_INC | CODE_NEXT, 1'b0, 8'd0);
        send_word(KIND_PRESS, CODE_INC, 1'b0, 8'd0);
        send_word(KIND_PRESS, CODE_NEXT, 1'b1, 8'd0);

        // Inverted range: writes collapse to its minimum
        wait_drained();
        set_range(8'd200, 8'd50);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd10);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd255);

        // Full range, then raise the minimum so the display sum wraps
        wait_drained();
        set_range(8'd0, 8'd255);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd200);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd255);
        send_word(KIND_WRITE, 4'd0, 1'b0, 8'd200);
        wait_drained();
        set_range(8'd100, 8'd255);
        send_word(KIND_CLEAR, 4'd0, 1'b0, 8'd0);

        // Settle out to idle, then increment from an offset beyond the span
        repeat (38) send_word(KIND_TICK, 4'd0, 1'b1, 8'd0);
        send_word(KIND_PRESS, CODE_INC, 1'b0, 8'd0);

        // Random phases: each with its own range and idling pattern
        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            set_range(lo_tab[p], hi_tab[p]);
            case (p % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 63;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 63;
                end
                default:
                begin
                    tx_idle_pct  = 22;
                    rx_stall_pct = 22;
                end
            endcase
            run_button_sequence();
            if ($urandom_range(3) == 0)
                wait_drained();
        end

        wait_drained();
        if (fail_count == 0 && pending_words == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/bdarc_pkg.sv
design/button_debounce_auto_repeat_counter.sv
bench/display_word_checker.sv
bench/button_debounce_auto_repeat_counter_test.sv
